// ===== design/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the packet framer with ping acknowledge.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // command codes carried on the input tuser
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  localparam logic [7:0] PING_CODE = 8'd1;
  localparam logic [7:0] ACK_CODE  = 8'd2;

  localparam int unsigned HDR_BYTES = 5;   // type + 4 length bytes
  localparam int unsigned ACK_BYTES = 5;   // 2,0,0,0,0
  localparam int unsigned Q_DEPTH   = 2;   // job queue depth

  localparam int unsigned STEP_W  = 4;     // up to 10 bytes per job
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  // one classified item, ready for expansion into link bytes
  typedef struct packed {
    logic        has_hdr;
    logic        has_data;
    logic        has_ack;
    logic [7:0]  ptype;
    logic [31:0] plen;
    logic [7:0]  dbyte;
  } job_t;

endpackage

// ===== design/pfa_front.sv =====
// ----------------------------------------------------------------------------
// pfa_front
// Classifies accepted items, keeps the packet state and builds jobs.
// ----------------------------------------------------------------------------
module pfa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     cmd,
  input  logic [7:0]     packet_type,
  input  logic [31:0]    packet_length,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     rx_byte,
  output logic           push,
  output pfa_pkg::job_t  job
);
  import pfa_pkg::*;

  logic        sending, sending_next;
  logic        ack_pending, ack_pending_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] rem_dec;

  assign rem_dec = bytes_remaining - 32'd1;

  always_comb begin
    sending_next         = sending;
    ack_pending_next     = ack_pending;
    bytes_remaining_next = bytes_remaining;
    job          = '0;
    job.ptype    = packet_type;
    job.plen     = packet_length;
    job.dbyte    = data_byte;
    case (cmd)
      CMD_START: begin
        if (!sending) begin
          job.has_hdr = 1'b1;
          bytes_remaining_next = packet_length;
          if (packet_length != 32'd0) begin
            sending_next = 1'b1;
          end else if (ack_pending) begin
            job.has_ack      = 1'b1;
            ack_pending_next = 1'b0;
          end
        end
      end
      CMD_DATA: begin
        if (sending) begin
          job.has_data         = 1'b1;
          bytes_remaining_next = rem_dec;
          if (rem_dec == 32'd0) begin
            sending_next = 1'b0;
            if (ack_pending) begin
              job.has_ack      = 1'b1;
              ack_pending_next = 1'b0;
            end
          end
        end
      end
      CMD_RX: begin
        if (rx_byte == PING_CODE) begin
          if (sending) begin
            ack_pending_next = 1'b1;
          end else begin
            job.has_ack      = 1'b1;
            ack_pending_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && (job.has_hdr || job.has_data || job.has_ack);

  always_ff @(posedge clk) begin
    if (rst) begin
      sending         <= 1'b0;
      ack_pending     <= 1'b0;
      bytes_remaining <= '0;
    end else if (accept) begin
      sending         <= sending_next;
      ack_pending     <= ack_pending_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ===== design/pfa_queue.sv =====
// ----------------------------------------------------------------------------
// pfa_queue
// Short job queue between the front and back halves.
// ----------------------------------------------------------------------------
module pfa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pfa_pkg::job_t  push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output pfa_pkg::job_t  head_job
);
  import pfa_pkg::*;

  job_t              slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = (count == QCNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/pfa_back.sv =====
// ----------------------------------------------------------------------------
// pfa_back
// Expands the head job into link bytes, one per cycle while m_tready allows, into an output register.
// ----------------------------------------------------------------------------
module pfa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  pfa_pkg::job_t  head_job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);
  import pfa_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] seg_len, total, ack_idx;
  logic              load, is_last, in_seg;
  logic [7:0]        byte_sel;

  assign seg_len = head_job.has_hdr  ? STEP_W'(HDR_BYTES) :
                   head_job.has_data ? STEP_W'(1) : '0;
  assign total   = seg_len + (head_job.has_ack ? STEP_W'(ACK_BYTES) : '0);
  assign in_seg  = (step < seg_len);
  assign ack_idx = step - seg_len;
  assign is_last = (step == total - 1'b1);
  assign load    = head_valid && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_comb begin
    byte_sel = 8'h00;
    if (in_seg) begin
      if (head_job.has_hdr) begin
        case (step[2:0])
          3'd0:    byte_sel = head_job.ptype;
          3'd1:    byte_sel = head_job.plen[31:24];
          3'd2:    byte_sel = head_job.plen[23:16];
          3'd3:    byte_sel = head_job.plen[15:8];
          default: byte_sel = head_job.plen[7:0];
        endcase
      end else begin
        byte_sel = head_job.dbyte;
      end
    end else if (ack_idx == '0) begin
      byte_sel = ACK_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tuser <= !in_seg;
      m_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        step     <= is_last ? '0 : step + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/packet_framer_with_ping_ack.sv =====
// ----------------------------------------------------------------------------
// packet_framer_with_ping_ack
// Transmit framer: type-length header, payload bytes, deferred ping acknowledge.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser cmd, tdata type/length/data/rx
//  m_      | out | m_tvalid/m_tready  | tdata tx_byte, tuser is_ack, tlast last
//
//  Input items are taken one per cycle while the job queue has room; the
//  front updates packet state in the accept cycle. The back half sends one
//  byte per cycle while m_tready allows: a payload item is 1 byte, a header
//  5, an ack frame 5 (up to 10 for one item). s_tready drops while the
//  two-entry job queue is full, which happens when items keep arriving
//  during a header or ack burst, or under output backpressure.
//  Synchronous reset clears the packet state, the queue and the output valid.
// ----------------------------------------------------------------------------
module packet_framer_with_ping_ack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // packet_type[7:0], packet_length[39:8],
                                 // data_byte[47:40], rx_byte[55:48]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // tx_byte[7:0]
  output logic        m_tuser,   // is_ack[0]
  output logic        m_tlast
);
  import pfa_pkg::*;

  logic accept;
  logic push, pop, q_full, head_valid;
  job_t job, head_job;

  // items with no result are taken too, but only while a slot is free
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // front: classify the item and advance the packet state
  pfa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (s_tuser),
    .packet_type   (s_tdata[7:0]),
    .packet_length (s_tdata[39:8]),
    .data_byte     (s_tdata[47:40]),
    .rx_byte       (s_tdata[55:48]),
    .push          (push),
    .job           (job)
  );

  // short queue so front and back stall independently
  pfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: serialise each job onto the link
  pfa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
